// ===== hw/rtl/sss_pkg.sv =====
package sss_pkg;

   localparam logic [3:0] SYM_DASH  = 4'd10;
   localparam logic [3:0] SYM_BLANK = 4'd11;
   localparam logic [3:0] SYM_I     = 4'd12;
   localparam logic [3:0] SYM_P     = 4'd13;

   localparam logic [15:0] SLOT_A_MS = 16'd2000;
   localparam logic [15:0] SLOT_B_MS = 16'd4000;
   localparam logic [15:0] SLOT_C_MS = 16'd6000;
   localparam logic [15:0] SLOT_D_MS = 16'd8000;

   localparam logic [13:0] VOLT_MAX_TENTHS = 14'd999;
   localparam logic [13:0] CURRENT_MAX_MA  = 14'd9999;

   localparam logic [3:0] CSR_OCTET_A   = 4'd0;
   localparam logic [3:0] CSR_OCTET_B   = 4'd1;
   localparam logic [3:0] CSR_OCTET_C   = 4'd2;
   localparam logic [3:0] CSR_OCTET_D   = 4'd3;
   localparam logic [3:0] CSR_IP_VALID  = 4'd4;
   localparam logic [3:0] CSR_BRIGHT    = 4'd5;
   localparam logic [3:0] CSR_WINDOW_MS = 4'd6;
   localparam logic [3:0] CSR_CYCLE_MS  = 4'd7;

   localparam logic [15:0] WINDOW_MS_RESET = 16'd10000;
   localparam logic [15:0] CYCLE_MS_RESET  = 16'd3000;

   localparam logic [1:0] KIND_LABEL   = 2'd0;
   localparam logic [1:0] KIND_OCTET   = 2'd1;
   localparam logic [1:0] KIND_VOLTAGE = 2'd2;
   localparam logic [1:0] KIND_CURRENT = 2'd3;

   typedef struct packed {
      logic [7:0]  octet_a;
      logic [7:0]  octet_b;
      logic [7:0]  octet_c;
      logic [7:0]  octet_d;
      logic        ip_valid;
      logic [2:0]  brightness;
      logic [15:0] ip_window_ms;
      logic [15:0] cycle_ms;
   } sss_cfg_type;

   typedef struct packed {
      logic               in_window;
      logic [15:0]        elapsed;
      logic               show_current;
      logic signed [15:0] voltage_mv;
      logic signed [19:0] current_q4;
   } sss_track_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [13:0] value;
   } sss_scale_type;

   typedef struct packed {
      logic [3:0] digit_left;
      logic [3:0] digit_two;
      logic [3:0] digit_three;
      logic [3:0] digit_right;
      logic [3:0] sys_param;
   } sss_disp_type;

endpackage

// ===== hw/rtl/sss_track.sv =====
module sss_track (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [31:0]           now_ms,
   input  logic signed [15:0]    voltage_mv,
   input  logic signed [19:0]    current_q4,
   input  sss_pkg::sss_cfg_type  cfg,
   input  logic                  down_ready,
   output logic                  up_ready,
   output logic                  out_valid,
   output sss_pkg::sss_track_type out_data
);
   import sss_pkg::*;

   logic          started_ff, started_in;
   logic [31:0]   start_ff, start_in;
   logic [31:0]   switch_ff, switch_in;
   logic          show_ff, show_in;
   logic          valid_ff, valid_in;
   sss_track_type data_ff, data_in;

   logic          accept;
   logic [31:0]   start_eff, switch_eff, elapsed, since_switch;
   logic          show_eff, in_window, toggle, show_new;

   assign up_ready = !valid_ff || down_ready;
   assign accept   = in_valid && up_ready;

   always_comb begin
      start_eff    = started_ff ? start_ff : now_ms;
      switch_eff   = started_ff ? switch_ff : now_ms;
      show_eff     = started_ff && show_ff;
      elapsed      = now_ms - start_eff;
      since_switch = now_ms - switch_eff;
      in_window    = elapsed < {16'd0, cfg.ip_window_ms};
      toggle       = !in_window && (since_switch >= {16'd0, cfg.cycle_ms});
      show_new     = show_eff ^ toggle;

      started_in = started_ff || accept;
      start_in   = (accept && !started_ff) ? now_ms : start_ff;
      switch_in  = (accept && (!started_ff || toggle)) ? now_ms : switch_ff;
      show_in    = accept ? show_new : show_ff;

      valid_in = accept ? 1'b1 : (down_ready ? 1'b0 : valid_ff);
      data_in  = data_ff;
      if (accept) begin
         data_in.in_window    = in_window;
         data_in.elapsed      = elapsed[15:0];
         data_in.show_current = show_new;
         data_in.voltage_mv   = voltage_mv;
         data_in.current_q4   = current_q4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         start_ff   <= 32'd0;
         switch_ff  <= 32'd0;
         show_ff    <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         started_ff <= started_in;
         start_ff   <= start_in;
         switch_ff  <= switch_in;
         show_ff    <= show_in;
         valid_ff   <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   a_started_after_transfer: assert property (@(posedge clock) disable iff (reset)
      accept |=> started_ff)
      else $error("started not set after transfer");

   a_start_time_held: assert property (@(posedge clock) disable iff (reset)
      (accept && started_ff) |=> (start_ff == $past(start_ff)))
      else $error("start time moved after first tick");

   a_idle_before_start: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (!show_ff && !valid_ff))
      else $error("state active before first tick");

endmodule

// ===== hw/rtl/sss_scale.sv =====
module sss_scale (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  sss_pkg::sss_track_type in_data,
   input  sss_pkg::sss_cfg_type   cfg,
   input  logic                   down_ready,
   output logic                   up_ready,
   output logic                   out_valid,
   output sss_pkg::sss_scale_type out_data
);
   import sss_pkg::*;

   logic          valid_ff, valid_in;
   sss_scale_type data_ff, data_in;

   logic          accept;
   logic [7:0]    octet, octet_eff;
   logic [14:0]   mv_pos;
   logic [15:0]   mv_sum;
   logic [31:0]   mv_prod;
   logic [9:0]    volt_q;
   logic [13:0]   volt_val;
   logic [19:0]   cur_sum;
   logic [15:0]   cur_q;
   logic [13:0]   cur_val;

   assign up_ready = !valid_ff || down_ready;
   assign accept   = in_valid && up_ready;

   always_comb begin
      if (in_data.elapsed < SLOT_B_MS) begin
         octet = cfg.octet_a;
      end else if (in_data.elapsed < SLOT_C_MS) begin
         octet = cfg.octet_b;
      end else if (in_data.elapsed < SLOT_D_MS) begin
         octet = cfg.octet_c;
      end else begin
         octet = cfg.octet_d;
      end
      octet_eff = cfg.ip_valid ? octet : 8'd0;

      // rounded tenths of a volt, divide by 100 through reciprocal
      mv_pos   = in_data.voltage_mv[15] ? 15'd0 : in_data.voltage_mv[14:0];
      mv_sum   = {1'b0, mv_pos} + 16'd50;
      mv_prod  = 32'(mv_sum) * 32'd41944;
      volt_q   = mv_prod[31:22];
      volt_val = ({4'd0, volt_q} > VOLT_MAX_TENTHS) ? VOLT_MAX_TENTHS : {4'd0, volt_q};

      cur_sum = in_data.current_q4[19] ? 20'd0 : ({1'b0, in_data.current_q4[18:0]} + 20'd8);
      cur_q   = cur_sum[19:4];
      cur_val = (cur_q > {2'd0, CURRENT_MAX_MA}) ? CURRENT_MAX_MA : cur_q[13:0];

      valid_in = accept ? 1'b1 : (down_ready ? 1'b0 : valid_ff);
      data_in  = data_ff;
      if (accept) begin
         if (in_data.in_window) begin
            if (in_data.elapsed < SLOT_A_MS) begin
               data_in.kind  = KIND_LABEL;
               data_in.value = 14'd0;
            end else begin
               data_in.kind  = KIND_OCTET;
               data_in.value = {6'd0, octet_eff};
            end
         end else if (in_data.show_current) begin
            data_in.kind  = KIND_CURRENT;
            data_in.value = cur_val;
         end else begin
            data_in.kind  = KIND_VOLTAGE;
            data_in.value = volt_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/sss_digits.sv =====
module sss_digits (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  sss_pkg::sss_scale_type in_data,
   input  sss_pkg::sss_cfg_type   cfg,
   input  logic                   down_ready,
   output logic                   up_ready,
   output logic                   out_valid,
   output sss_pkg::sss_disp_type  out_data
);
   import sss_pkg::*;

   logic         valid_ff, valid_in;
   sss_disp_type data_ff, data_in;

   logic         accept;
   logic [13:0]  v;
   logic [29:0]  p10, p100;
   logic [28:0]  p1000;
   logic [10:0]  q10;
   logic [7:0]   q100;
   logic [4:0]   q1000;
   logic [13:0]  ones_full;
   logic [10:0]  tens_full;
   logic [7:0]   hund_full;
   logic [3:0]   d_ones, d_tens, d_hund, d_thou;

   assign up_ready = !valid_ff || down_ready;
   assign accept   = in_valid && up_ready;

   always_comb begin
      v = in_data.value;
      // constant reciprocals, exact for values up to 9999
      p10   = 30'(v) * 30'd52429;
      p100  = 30'(v) * 30'd41944;
      p1000 = 29'(v) * 29'd16778;
      q10   = p10[29:19];
      q100  = p100[29:22];
      q1000 = p1000[28:24];

      ones_full = v - 14'(q10) * 14'd10;
      tens_full = q10 - 11'(q100) * 11'd10;
      hund_full = q100 - 8'(q1000) * 8'd10;
      d_ones    = ones_full[3:0];
      d_tens    = tens_full[3:0];
      d_hund    = hund_full[3:0];
      d_thou    = q1000[3:0];

      valid_in = accept ? 1'b1 : (down_ready ? 1'b0 : valid_ff);
      data_in  = data_ff;
      if (accept) begin
         data_in.sys_param = {cfg.brightness, 1'b1};
         case (in_data.kind)
            KIND_LABEL: begin
               data_in.digit_left  = SYM_I;
               data_in.digit_two   = SYM_P;
               data_in.digit_three = SYM_BLANK;
               data_in.digit_right = SYM_BLANK;
            end
            KIND_OCTET: begin
               data_in.digit_left  = SYM_BLANK;
               data_in.digit_two   = (v >= 14'd100) ? d_hund : SYM_BLANK;
               data_in.digit_three = (v >= 14'd10) ? d_tens : SYM_BLANK;
               data_in.digit_right = d_ones;
            end
            KIND_VOLTAGE: begin
               data_in.digit_left  = (q100 != 8'd0) ? d_hund : SYM_BLANK;
               data_in.digit_two   = d_tens;
               data_in.digit_three = SYM_DASH;
               data_in.digit_right = d_ones;
            end
            default: begin
               data_in.digit_left  = (q1000 != 5'd0) ? d_thou : SYM_BLANK;
               data_in.digit_two   = (v >= 14'd100) ? d_hund : SYM_BLANK;
               data_in.digit_three = (v >= 14'd10) ? d_tens : SYM_BLANK;
               data_in.digit_right = d_ones;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/seven_segment_status_sequencer_core.sv =====
// channel | ports                                        | direction
// req     | req_valid req_stall req_now_ms               | in
//         | req_voltage_mv req_current_q4                |
// rsp     | rsp_valid rsp_stall rsp_digit_left/two/three | out
//         | rsp_digit_right rsp_sys_param                |
// csr     | csr_write csr_index csr_wdata                | in, write only
//
// one transfer per cycle sustained while rsp_stall is low
// a request passes through three register stages: time tracking, scaling, digit split
// synchronous reset clears the phase state and all stage valids, csr registers to defaults
// a stalled response holds every stage that is full; empty stages still fill
module seven_segment_status_sequencer_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_now_ms,
   input  logic signed [15:0] req_voltage_mv,
   input  logic signed [19:0] req_current_q4,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_digit_left,
   output logic [3:0]         rsp_digit_two,
   output logic [3:0]         rsp_digit_three,
   output logic [3:0]         rsp_digit_right,
   output logic [3:0]         rsp_sys_param,
   input  logic               csr_write,
   input  logic [3:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import sss_pkg::*;

   sss_cfg_type   cfg_ff, cfg_in;
   sss_track_type track_data;
   sss_scale_type scale_data;
   sss_disp_type  disp_data;
   logic          track_valid, scale_valid;
   logic          track_ready, scale_ready, digits_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_OCTET_A:   cfg_in.octet_a      = csr_wdata[7:0];
            CSR_OCTET_B:   cfg_in.octet_b      = csr_wdata[7:0];
            CSR_OCTET_C:   cfg_in.octet_c      = csr_wdata[7:0];
            CSR_OCTET_D:   cfg_in.octet_d      = csr_wdata[7:0];
            CSR_IP_VALID:  cfg_in.ip_valid     = csr_wdata[0];
            CSR_BRIGHT:    cfg_in.brightness   = csr_wdata[2:0];
            CSR_WINDOW_MS: cfg_in.ip_window_ms = csr_wdata;
            CSR_CYCLE_MS:  cfg_in.cycle_ms     = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.octet_a      <= 8'd0;
         cfg_ff.octet_b      <= 8'd0;
         cfg_ff.octet_c      <= 8'd0;
         cfg_ff.octet_d      <= 8'd0;
         cfg_ff.ip_valid     <= 1'b0;
         cfg_ff.brightness   <= 3'd0;
         cfg_ff.ip_window_ms <= WINDOW_MS_RESET;
         cfg_ff.cycle_ms     <= CYCLE_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sss_track u_track (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .now_ms     (req_now_ms),
      .voltage_mv (req_voltage_mv),
      .current_q4 (req_current_q4),
      .cfg        (cfg_ff),
      .down_ready (scale_ready),
      .up_ready   (track_ready),
      .out_valid  (track_valid),
      .out_data   (track_data)
   );

   sss_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (track_valid),
      .in_data    (track_data),
      .cfg        (cfg_ff),
      .down_ready (digits_ready),
      .up_ready   (scale_ready),
      .out_valid  (scale_valid),
      .out_data   (scale_data)
   );

   sss_digits u_digits (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (scale_valid),
      .in_data    (scale_data),
      .cfg        (cfg_ff),
      .down_ready (!rsp_stall),
      .up_ready   (digits_ready),
      .out_valid  (rsp_valid),
      .out_data   (disp_data)
   );

   assign req_stall       = !track_ready;
   assign rsp_digit_left  = disp_data.digit_left;
   assign rsp_digit_two   = disp_data.digit_two;
   assign rsp_digit_three = disp_data.digit_three;
   assign rsp_digit_right = disp_data.digit_right;
   assign rsp_sys_param   = disp_data.sys_param;

endmodule
